// ===== design/rhs_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rhs_pkg: shared types and constants of the register hazard scoreboard
// Item layout, command codes and the update control bundle.
// ----------------------------------------------------------------------------
package rhs_pkg;

	// fixed field widths
	localparam int REG_W      = 5;
	localparam int CMD_W      = 2;
	localparam int SRC_CNT_W  = 2;
	localparam int ITEM_W     = CMD_W + 1 + REG_W + SRC_CNT_W + REG_W + REG_W;
	localparam int IN_DATA_W  = ((ITEM_W + 7) / 8) * 8;
	localparam int OUT_DATA_W = 8;

	// defaults for the top-level parameters
	localparam int DEF_NUM_REGS    = 32;
	localparam int DEF_COUNT_WIDTH = 5;

	// command codes; code three performs no update
	typedef enum logic [CMD_W-1:0] {
		CMD_RAISE = 2'd0,
		CMD_LOWER = 2'd1,
		CMD_CHECK = 2'd2
	} cmd_t;

	// one input item, last field (command) in the lowest bits
	typedef struct packed {
		logic [REG_W-1:0]     src_b;
		logic [REG_W-1:0]     src_a;
		logic [SRC_CNT_W-1:0] src_count;
		logic [REG_W-1:0]     dest_reg;
		logic                 has_dest;
		logic [CMD_W-1:0]     command;
	} item_t;

	// counter update control shared by all cells
	typedef struct packed {
		logic en;
		logic up;
	} upd_t;

endpackage

// ===== design/rhs_decode.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rhs_decode: item decoder
// Turns the registered item into per-register hit masks, read increments and
// the common update control.
// ----------------------------------------------------------------------------
module rhs_decode import rhs_pkg::*; #(
	parameter int NUM_REGS = DEF_NUM_REGS
) (
	input  item_t                     item,
	input  logic                      advance,
	output logic [NUM_REGS-1:0]       dest_hit,
	output logic [NUM_REGS-1:0]       src_hit,
	output logic [NUM_REGS-1:0][1:0]  rd_inc,
	output upd_t                      upd
);

	localparam int IDX_W = (NUM_REGS > 1) ? $clog2(NUM_REGS) : 1;
	localparam int CMP_W = (REG_W > IDX_W) ? REG_W : IDX_W;

	logic use_a;
	logic use_b;

	// source count three acts as two
	assign use_a = (item.src_count != '0);
	assign use_b = item.src_count[1];

	// map the command onto the counter update
	always_comb begin
		upd = '0;
		case (cmd_t'(item.command))
			CMD_RAISE: begin
				upd.en = advance;
				upd.up = 1'b1;
			end
			CMD_LOWER: begin
				upd.en = advance;
				upd.up = 1'b0;
			end
			default: begin
				upd = '0;
			end
		endcase
	end

	// compare each register number; numbers beyond the file match no cell
	for (genvar i = 0; i < NUM_REGS; i++) begin : g_reg
		localparam logic [CMP_W-1:0] IDX = CMP_W'(i);
		logic a_hit;
		logic b_hit;

		assign a_hit       = use_a && (CMP_W'(item.src_a) == IDX);
		assign b_hit       = use_b && (CMP_W'(item.src_b) == IDX);
		assign dest_hit[i] = item.has_dest && (CMP_W'(item.dest_reg) == IDX);
		assign src_hit[i]  = a_hit | b_hit;
		assign rd_inc[i]   = {1'b0, a_hit} + {1'b0, b_hit};
	end

endmodule

// ===== design/rhs_cell.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rhs_cell: counters of one architectural register
// Holds the saturating pending-read and pending-write counts and flags
// whether each is nonzero.
// ----------------------------------------------------------------------------
module rhs_cell import rhs_pkg::*; #(
	parameter int COUNT_WIDTH = DEF_COUNT_WIDTH
) (
	input  logic       clk,
	input  logic       arst_n,
	input  upd_t       upd,
	input  logic       wr_hit,
	input  logic [1:0] rd_inc,
	output logic       rd_nz,
	output logic       wr_nz
);

	localparam int CW = COUNT_WIDTH;
	localparam logic [CW-1:0] CNT_MAX = '1;

	logic [CW-1:0] rd_cnt_q;
	logic [CW-1:0] wr_cnt_q;

	// add or subtract a small step, clamped at both ends
	function automatic logic [CW-1:0] bump(input logic [CW-1:0] cnt,
			input logic [1:0] inc, input logic up);
		logic [CW:0] sum;
		logic [CW:0] dif;
		sum = {1'b0, cnt} + (CW+1)'(inc);
		dif = {1'b0, cnt} - (CW+1)'(inc);
		if (up) begin
			if (sum > {1'b0, CNT_MAX})
				return CNT_MAX;
			return sum[CW-1:0];
		end
		if (dif[CW])
			return '0;
		return dif[CW-1:0];
	endfunction

	// update both counters on an advancing raise or lower
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rd_cnt_q <= '0;
			wr_cnt_q <= '0;
		end else if (upd.en) begin
			rd_cnt_q <= bump(rd_cnt_q, rd_inc, upd.up);
			wr_cnt_q <= bump(wr_cnt_q, {1'b0, wr_hit}, upd.up);
		end
	end

	assign rd_nz = (rd_cnt_q != '0);
	assign wr_nz = (wr_cnt_q != '0);

endmodule

// ===== design/register_hazard_scoreboard_core.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// register_hazard_scoreboard_core: counting register scoreboard
// Checks RAW, WAR and WAW hazards against per-register pending counts and
// then raises or lowers those counts.
//
// channel  dir  tdata fields (lowest bit up)
// s_*      in   command[1:0] has_dest dest_reg[4:0] src_count[1:0]
//               src_a[4:0] src_b[4:0], zero fill to 24 bits
// m_*      out  hazard, zero fill to 8 bits
//
// One beat per cycle sustained while m_tready stays high; each result passes
// the input register, then the result register, before it is shown on m_*.
// The hazard is judged on the counts left by all earlier beats, since the
// counters update in the same cycle the beat leaves the input register.
// Reset clears all counters and both stage valids at once.
// A stalled result holds the input register; s_tready stays high while that
// register is empty, so one more beat is taken behind a waiting result.
// ----------------------------------------------------------------------------
module register_hazard_scoreboard_core import rhs_pkg::*; #(
	parameter int NUM_REGS    = DEF_NUM_REGS,
	parameter int COUNT_WIDTH = DEF_COUNT_WIDTH
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  s_tvalid,
	output logic                  s_tready,
	// command, has_dest, dest_reg, src_count, src_a, src_b
	input  logic [IN_DATA_W-1:0]  s_tdata,
	output logic                  m_tvalid,
	input  logic                  m_tready,
	// hazard
	output logic [OUT_DATA_W-1:0] m_tdata
);

	item_t                     item_s1;
	logic                      valid_s1;
	logic                      out_valid_q;
	logic                      hazard_q;
	logic                      advance;
	logic                      hazard_d;
	logic [NUM_REGS-1:0]       dest_hit;
	logic [NUM_REGS-1:0]       src_hit;
	logic [NUM_REGS-1:0][1:0]  rd_inc;
	logic [NUM_REGS-1:0]       rd_nz;
	logic [NUM_REGS-1:0]       wr_nz;
	upd_t                      upd;

	// move the held beat on when the result register is free
	assign advance  = valid_s1 && (!out_valid_q || m_tready);
	assign s_tready = !valid_s1 || advance;

	// input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_tready) begin
			valid_s1 <= s_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_tvalid && s_tready)
			item_s1 <= item_t'(s_tdata[ITEM_W-1:0]);
	end

	rhs_decode #(
		.NUM_REGS(NUM_REGS)
	) u_decode (
		.item    (item_s1),
		.advance (advance),
		.dest_hit(dest_hit),
		.src_hit (src_hit),
		.rd_inc  (rd_inc),
		.upd     (upd)
	);

	for (genvar i = 0; i < NUM_REGS; i++) begin : g_cell
		rhs_cell #(
			.COUNT_WIDTH(COUNT_WIDTH)
		) u_cell (
			.clk   (clk),
			.arst_n(arst_n),
			.upd   (upd),
			.wr_hit(dest_hit[i]),
			.rd_inc(rd_inc[i]),
			.rd_nz (rd_nz[i]),
			.wr_nz (wr_nz[i])
		);
	end

	// WAR or WAW on the destination, RAW on any source
	assign hazard_d = (|(dest_hit & (rd_nz | wr_nz))) || (|(src_hit & wr_nz));

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (advance) begin
			out_valid_q <= 1'b1;
		end else if (m_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance)
			hazard_q <= hazard_d;
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata  = {(OUT_DATA_W-1)'(0), hazard_q};

	// an empty input register always takes a beat
	a_ready_when_empty: assert property (@(posedge clk) disable iff (!arst_n)
		!valid_s1 |-> s_tready)
		else $error("input refused while input register empty");

	// a full input register behind a stalled result takes nothing
	a_hold_on_stall: assert property (@(posedge clk) disable iff (!arst_n)
		(valid_s1 && out_valid_q && !m_tready) |-> !s_tready)
		else $error("beat taken while pipeline stalled");

	// an advancing beat always produces a result next cycle
	a_result_follows: assert property (@(posedge clk) disable iff (!arst_n)
		advance |=> m_tvalid)
		else $error("advanced beat produced no result");

	// a held beat is not lost while it waits
	a_keep_held: assert property (@(posedge clk) disable iff (!arst_n)
		(valid_s1 && !advance) |=> valid_s1)
		else $error("held beat dropped");

	// counters change only when a beat advances
	a_update_gated: assert property (@(posedge clk) disable iff (!arst_n)
		upd.en |-> advance)
		else $error("counter update without advance");

endmodule
